// ===== hw/rtl/open_address_hash_lookup_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the open-address hash lookup
// Clocked implication checks, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef OPEN_ADDRESS_HASH_LOOKUP_DEFINES_SVH
`define OPEN_ADDRESS_HASH_LOOKUP_DEFINES_SVH

// same-cycle implication
`define OAHL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication
`define OAHL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== hw/rtl/oahl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oahl_pkg
// Widths, opcodes, status codes and register map of the hash lookup.
// ----------------------------------------------------------------------------
package oahl_pkg;

  localparam int TBL_DEPTH = 1024;
  localparam int ADDR_W    = $clog2(TBL_DEPTH);
  localparam int SIZE_W    = 11;
  localparam int KEY_W     = 32;
  localparam int PAY_W     = 32;
  localparam int OP_W      = 2;
  localparam int STAT_W    = 2;
  localparam int REM_W     = ADDR_W + 2;
  localparam int DIV_W     = KEY_W + 1;
  localparam int CNT_W     = $clog2(DIV_W);
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd1;
  localparam logic [OP_W-1:0] OP_REPLACE = 2'd2;

  localparam logic [CFG_AW-3:0] REG_TABLE_SIZE = 1'b0;

  typedef enum logic [STAT_W-1:0] {
    ST_FOUND     = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_LIMIT     = 2'd2,
    ST_SIZE_ZERO = 2'd3
  } status_t;

endpackage

// ===== hw/rtl/open_address_hash_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_address_hash_lookup
// Open-addressing hash table with load, lookup and lookup-and-replace.
// ----------------------------------------------------------------------------
// A load, and a lookup with table_size zero, is answered in the cycle after
// the request. For other lookups each probe index comes out of one shared
// remainder unit that retires one bit of a 33-bit dividend per cycle, then
// the key and payload memories are read and the key compared. A lookup stops
// on a match, on an empty slot, or after table_size probes (at most 1024).
// After reset every slot of the key memory is swept to zero, during which no
// request is taken; register writes are taken at all times. One request is
// in flight at a time.
`include "open_address_hash_lookup_defines.svh"

module open_address_hash_lookup (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [oahl_pkg::OP_W-1:0]          in_opcode,
  input  logic [oahl_pkg::ADDR_W-1:0]        in_slot,
  input  logic [oahl_pkg::KEY_W-1:0]         in_key,
  input  logic [oahl_pkg::PAY_W-1:0]         in_payload,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [oahl_pkg::STAT_W-1:0]        out_status,
  output logic [oahl_pkg::ADDR_W-1:0]        out_found_slot,
  output logic [oahl_pkg::PAY_W-1:0]         out_old_payload,
  output logic [oahl_pkg::SIZE_W-1:0]        out_probe_count,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [oahl_pkg::CFG_AW-1:0]        paddr,
  input  logic [oahl_pkg::CFG_DW-1:0]        pwdata,
  output logic [oahl_pkg::CFG_DW-1:0]        prdata,
  output logic                               pready
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_READ,
    S_CHECK
  } state_t;

  state_t                             state_r;
  logic [oahl_pkg::ADDR_W-1:0]        clr_cnt_r;
  logic [oahl_pkg::SIZE_W-1:0]        size_r;
  logic [oahl_pkg::OP_W-1:0]          op_r;
  logic [oahl_pkg::KEY_W-1:0]         key_r;
  logic [oahl_pkg::PAY_W-1:0]         pay_r;
  logic [oahl_pkg::KEY_W-1:0]         st_r;
  logic [oahl_pkg::ADDR_W-1:0]        s_r;
  logic [oahl_pkg::REM_W-1:0]         rem_r;
  logic [oahl_pkg::DIV_W-1:0]         div_r;
  logic [oahl_pkg::CNT_W-1:0]         cnt_r;
  logic [oahl_pkg::SIZE_W-1:0]        probes_r;

  logic                               out_valid_r;
  oahl_pkg::status_t                  out_status_r;
  logic [oahl_pkg::ADDR_W-1:0]        out_slot_r;
  logic [oahl_pkg::PAY_W-1:0]         out_pay_r;
  logic [oahl_pkg::SIZE_W-1:0]        out_probes_r;

  logic [oahl_pkg::KEY_W-1:0]         key_mem [oahl_pkg::TBL_DEPTH];
  logic [oahl_pkg::PAY_W-1:0]         pay_mem [oahl_pkg::TBL_DEPTH];
  logic [oahl_pkg::KEY_W-1:0]         key_rd_r;
  logic [oahl_pkg::PAY_W-1:0]         pay_rd_r;

  logic                               in_acc;
  logic                               reply_now;
  logic                               cfg_wr;
  logic                               ld_ok;
  logic [oahl_pkg::REM_W-1:0]         eff_size;
  logic [oahl_pkg::REM_W-1:0]         trial;
  logic [oahl_pkg::REM_W-1:0]         rem_nxt;
  logic [oahl_pkg::KEY_W-1:0]         st_nxt;
  logic [oahl_pkg::DIV_W-1:0]         sum_nxt;
  logic [oahl_pkg::SIZE_W-1:0]        probes_nxt;
  logic                               limit_hit;
  logic                               hit;

  logic                               key_we;
  logic [oahl_pkg::ADDR_W-1:0]        key_wa;
  logic [oahl_pkg::KEY_W-1:0]         key_wd;
  logic                               pay_we;
  logic [oahl_pkg::ADDR_W-1:0]        pay_wa;
  logic [oahl_pkg::PAY_W-1:0]         pay_wd;

  assign in_stall  = !((state_r == S_IDLE) && (!out_valid_r || !out_stall));
  assign in_acc    = in_valid && !in_stall;
  assign reply_now = in_acc && ((in_opcode == oahl_pkg::OP_LOAD) || (eff_size == '0));
  assign cfg_wr    = psel && penable && pwrite &&
                     (paddr[oahl_pkg::CFG_AW-1:2] == oahl_pkg::REG_TABLE_SIZE);
  assign pready    = 1'b1;
  assign prdata    = (paddr[oahl_pkg::CFG_AW-1:2] == oahl_pkg::REG_TABLE_SIZE) ?
                     oahl_pkg::CFG_DW'(size_r) : '0;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_slot  = out_slot_r;
  assign out_old_payload = out_pay_r;
  assign out_probe_count = out_probes_r;

  assign ld_ok = 32'(in_slot) < 32'(oahl_pkg::TBL_DEPTH);

  assign eff_size = (oahl_pkg::REM_W'(size_r) > oahl_pkg::REM_W'(oahl_pkg::TBL_DEPTH)) ?
                    oahl_pkg::REM_W'(oahl_pkg::TBL_DEPTH) : oahl_pkg::REM_W'(size_r);

  assign trial      = {rem_r[oahl_pkg::REM_W-2:0], div_r[oahl_pkg::DIV_W-1]};
  assign rem_nxt    = (trial >= eff_size) ? trial - eff_size : trial;
  assign st_nxt     = {1'b0, st_r[oahl_pkg::KEY_W-1:1]} + oahl_pkg::KEY_W'(1);
  assign sum_nxt    = oahl_pkg::DIV_W'(st_nxt) + oahl_pkg::DIV_W'(s_r);
  assign probes_nxt = probes_r + oahl_pkg::SIZE_W'(1);
  assign limit_hit  = oahl_pkg::REM_W'(probes_nxt) >= eff_size;
  assign hit        = (key_rd_r != '0) && (key_rd_r == key_r);

  always_comb begin
    key_we = 1'b0;
    key_wa = in_slot;
    key_wd = in_key;
    pay_we = 1'b0;
    pay_wa = in_slot;
    pay_wd = in_payload;
    if (state_r == S_CLEAR) begin
      key_we = 1'b1;
      key_wa = clr_cnt_r;
      key_wd = '0;
    end else if (in_acc && (in_opcode == oahl_pkg::OP_LOAD) && ld_ok) begin
      key_we = 1'b1;
      pay_we = 1'b1;
    end else if ((state_r == S_CHECK) && hit && (op_r == oahl_pkg::OP_REPLACE)) begin
      pay_we = 1'b1;
      pay_wa = s_r;
      pay_wd = pay_r;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    key_rd_r <= key_mem[s_r];
  end

  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_mem[pay_wa] <= pay_wd;
    end
    pay_rd_r <= pay_mem[s_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      size_r      <= '0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
      s_r         <= '0;
    end else begin
      if (cfg_wr) begin
        size_r <= pwdata[oahl_pkg::SIZE_W-1:0];
      end
      if (out_valid_r && !out_stall && !reply_now) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + oahl_pkg::ADDR_W'(1);
          if (clr_cnt_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            op_r  <= in_opcode;
            key_r <= in_key;
            pay_r <= in_payload;
            if (in_opcode == oahl_pkg::OP_LOAD) begin
              out_valid_r  <= 1'b1;
              out_status_r <= oahl_pkg::ST_FOUND;
              out_slot_r   <= in_slot;
              out_pay_r    <= '0;
              out_probes_r <= '0;
            end else if (eff_size == '0) begin
              out_valid_r  <= 1'b1;
              out_status_r <= oahl_pkg::ST_SIZE_ZERO;
              out_slot_r   <= '0;
              out_pay_r    <= '0;
              out_probes_r <= '0;
            end else begin
              rem_r    <= '0;
              div_r    <= {1'b0, in_key};
              cnt_r    <= '0;
              st_r     <= in_key;
              probes_r <= '0;
              state_r  <= S_MOD;
            end
          end
        end
        S_MOD: begin
          rem_r <= rem_nxt;
          div_r <= div_r << 1;
          cnt_r <= cnt_r + oahl_pkg::CNT_W'(1);
          if (cnt_r == oahl_pkg::CNT_W'(oahl_pkg::DIV_W - 1)) begin
            s_r     <= rem_nxt[oahl_pkg::ADDR_W-1:0];
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          probes_r <= probes_nxt;
          if (key_rd_r == '0) begin
            out_valid_r  <= 1'b1;
            out_status_r <= oahl_pkg::ST_EMPTY;
            out_slot_r   <= '0;
            out_pay_r    <= '0;
            out_probes_r <= probes_nxt;
            state_r      <= S_IDLE;
          end else if (hit) begin
            out_valid_r  <= 1'b1;
            out_status_r <= oahl_pkg::ST_FOUND;
            out_slot_r   <= s_r;
            out_pay_r    <= pay_rd_r;
            out_probes_r <= probes_nxt;
            state_r      <= S_IDLE;
          end else if (limit_hit) begin
            out_valid_r  <= 1'b1;
            out_status_r <= oahl_pkg::ST_LIMIT;
            out_slot_r   <= '0;
            out_pay_r    <= '0;
            out_probes_r <= probes_nxt;
            state_r      <= S_IDLE;
          end else begin
            st_r    <= st_nxt;
            div_r   <= sum_nxt;
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_MOD;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `OAHL_ASSERT_IMP(a_no_req_in_clear, state_r == S_CLEAR, in_stall)
  `OAHL_ASSERT_IMP(a_rem_below_size, state_r == S_MOD, rem_r < eff_size)
  `OAHL_ASSERT_NXT(a_lookup_starts, in_acc && !reply_now, state_r == S_MOD)
  `OAHL_ASSERT_IMP(a_limit_count, out_valid_r && (out_status_r == oahl_pkg::ST_LIMIT), oahl_pkg::REM_W'(out_probes_r) == eff_size)
  `OAHL_ASSERT_IMP(a_empty_probed, out_valid_r && (out_status_r == oahl_pkg::ST_EMPTY), out_probes_r != '0)

endmodule
